/* sv/mfde_pkg.sv */
`default_nettype none
package mfde_pkg;

  localparam int COLUMNS     = 84;
  localparam int PAGES       = 6;
  localparam int ROW_BYTES   = 11;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_BYTES = ROWS * ROW_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int IDX_W       = 12;

  localparam logic [2:0] ACT_SET     = 3'd0;
  localparam logic [2:0] ACT_OUTLINE = 3'd1;
  localparam logic [2:0] ACT_FILL    = 3'd2;
  localparam logic [2:0] ACT_CLEAR   = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [6:0] rect_width;
    logic [5:0] rect_height;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] page_byte;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic              ok;
  } addr_t;

endpackage
`default_nettype wire

/* sv/mfde_addr.sv */
`default_nettype none
module mfde_addr (
  input  wire logic [7:0]     col,
  input  wire logic [6:0]     row,
  output mfde_pkg::addr_t     addr
);
  import mfde_pkg::*;

  logic [IDX_W-1:0] full;

  always_comb begin
    full = IDX_W'(row) * IDX_W'(ROW_BYTES) + IDX_W'(col[7:3]);
    addr.ok = (col < 8'(COLUMNS)) && (row < 7'(ROWS)) && (full < IDX_W'(STORE_BYTES));
    addr.idx = full[ADDR_W-1:0];
  end

endmodule
`default_nettype wire

/* sv/mono_framebuffer_draw_engine.sv */
// monochrome framebuffer draw engine, 84x48 pixels, one bit each
// cmd channel (cmd_valid/cmd_ready/cmd) carries one command per transaction:
//   set pixel, outline rect, filled rect, clear, read page byte
// rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per command
// one command is worked at a time; cmd_ready is high only while idle
// work per command, after it is accepted:
//   set pixel reads the store byte and writes it back with the bit set, no write when out of range
//   rectangle walks the w*h bounding box, reading and writing each drawn pixel, skipping the others
//   read page byte reads the 8 rows of the page one by one, no read when out of range
//   clear writes zero to all STORE_BYTES bytes (528)
//   unknown action does no store access
// the next command is taken the cycle after the result is registered
// reset starts a clearing pass over all STORE_BYTES bytes of the store, no command taken
// and no result given
// the result sits in an output register; a new command is taken while it waits,
// and the next result is held back until the receiver takes the previous one
`default_nettype none
module mono_framebuffer_draw_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire mfde_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output mfde_pkg::rsp_t      rsp
);
  import mfde_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_PIX  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RDC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;
  logic [6:0]        x;
  logic [5:0]        y;
  logic [6:0]        w;
  logic [5:0]        h;
  logic [6:0]        ci;
  logic [5:0]        cj;
  logic [2:0]        k;
  logic              filled;
  logic              status_r;
  logic [7:0]        byte_r;
  logic [ADDR_W-1:0] wr_addr;
  logic [2:0]        bit_sel;
  logic              rd_ok;

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_ra;

  logic [7:0]        col;
  logic [6:0]        row;
  addr_t             au;
  logic              ci_last;
  logic              cj_last;
  logic              draw;

  mfde_addr u_addr (
    .col  (col),
    .row  (row),
    .addr (au)
  );

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    if (state == S_RD) begin
      col = {1'b0, x};
      row = 7'({y[2:0], k});
    end else begin
      col = {1'b0, x} + {1'b0, ci};
      row = {1'b0, y} + {1'b0, cj};
    end
    ci_last = (ci == w - 7'd1);
    cj_last = (cj == h - 6'd1);
    draw = filled || (ci == 7'd0) || (cj == 6'd0) || ci_last || cj_last;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wr_addr;
    mem_wd = rd_data | (8'd1 << bit_sel);
    mem_re = 1'b0;
    mem_ra = au.idx;
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = 8'd0;
      end
      S_WR: begin
        mem_we = 1'b1;
      end
      S_PIX: begin
        mem_re = draw && au.ok;
      end
      S_RD: begin
        mem_re = au.ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            x        <= cmd.pos_x;
            y        <= cmd.pos_y;
            ci       <= '0;
            cj       <= '0;
            k        <= '0;
            byte_r   <= '0;
            unique case (cmd.action)
              ACT_SET: begin
                w        <= 7'd1;
                h        <= 6'd1;
                filled   <= 1'b1;
                status_r <= ({1'b0, cmd.pos_x} >= 8'(COLUMNS)) ||
                            ({1'b0, cmd.pos_y} >= 7'(ROWS));
                state    <= S_PIX;
              end
              ACT_OUTLINE, ACT_FILL: begin
                w        <= cmd.rect_width;
                h        <= cmd.rect_height;
                filled   <= (cmd.action == ACT_FILL);
                status_r <= 1'b0;
                if (cmd.rect_width == 7'd0 || cmd.rect_height == 6'd0) state <= S_DONE;
                else state <= S_PIX;
              end
              ACT_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                status_r  <= 1'b0;
                state     <= S_CLR;
              end
              ACT_READ: begin
                if ({1'b0, cmd.pos_x} >= 8'(COLUMNS) || cmd.pos_y >= 6'(PAGES)) begin
                  status_r <= 1'b1;
                  state    <= S_DONE;
                end else begin
                  status_r <= 1'b0;
                  state    <= S_RD;
                end
              end
              default: begin
                status_r <= 1'b0;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(STORE_BYTES - 1)) state <= clr_reply ? S_DONE : S_IDLE;
        end
        S_PIX, S_WR: begin
          if (state == S_PIX && draw && au.ok) begin
            wr_addr <= au.idx;
            bit_sel <= ~col[2:0];
            state   <= S_WR;
          end else begin
            // advance to the next pixel of the bounding box
            if (cj_last) begin
              cj <= '0;
              if (ci_last) state <= S_DONE;
              else begin
                ci    <= ci + 7'd1;
                state <= S_PIX;
              end
            end else begin
              cj    <= cj + 6'd1;
              state <= S_PIX;
            end
          end
        end
        S_RD: begin
          rd_ok <= au.ok;
          state <= S_RDC;
        end
        S_RDC: begin
          if (rd_ok) byte_r[k] <= rd_data[~x[2:0]];
          k <= k + 3'd1;
          if (k == 3'd7) state <= S_DONE;
          else state <= S_RD;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status    <= status_r;
            rsp.page_byte <= byte_r;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
